### sv/lrf_pkg.sv
package lrf_pkg;

   localparam int DataW   = 8;
   localparam int LenW    = 32;
   localparam int CrcW    = 32;
   localparam int OffW    = 48;
   localparam int LimitW  = 48;
   localparam int CsrDataW = 64;
   localparam int CsrAddrW = 4;

   localparam logic [CrcW-1:0]   CrcPreset  = 32'hFFFF_FFFF;
   localparam logic [CrcW-1:0]   CrcPoly    = 32'hEDB8_8320;
   localparam int                HeaderBytes = 8;
   localparam logic [LimitW-1:0] LimitReset = 48'd67108864;

   // register index is paddr bit 3 (8-byte register spacing)
   localparam logic RegSegmentLimit = 1'b0;

   typedef struct packed {
      logic [LenW-1:0] length;
      logic [CrcW-1:0] crc;
      logic            overflow;
   } rec_end_type;

   typedef struct packed {
      logic [LenW-1:0] payload_length;
      logic [CrcW-1:0] payload_crc;
      logic            start_new_segment;
      logic [OffW-1:0] record_offset;
      logic            length_error;
   } rsp_payload_type;

   // reflected crc-32, one byte, bit at a time
   function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [DataW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ CrcW'(b);
      for (int i = 0; i < DataW; i++) begin
         c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
      end
      return c;
   endfunction

endpackage

### sv/lrf_req_if.sv
interface lrf_req_if
   import lrf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [DataW-1:0] data_byte;
   logic             byte_present;
   logic             last_byte;

   modport source(output valid, data_byte, byte_present, last_byte, input ready);
   modport sink(input valid, data_byte, byte_present, last_byte, output ready);
endinterface

### sv/lrf_rsp_if.sv
interface lrf_rsp_if
   import lrf_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [LenW-1:0] payload_length;
   logic [CrcW-1:0] payload_crc;
   logic            start_new_segment;
   logic [OffW-1:0] record_offset;
   logic            length_error;

   modport source(output valid, payload_length, payload_crc, start_new_segment,
                  record_offset, length_error, input ready);
   modport sink(input valid, payload_length, payload_crc, start_new_segment,
                record_offset, length_error, output ready);
endinterface

### sv/lrf_segment.sv
module lrf_segment
   import lrf_pkg::*;
#(
   parameter int SEGMENT_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LimitW-1:0]   limit,
   input  logic                take,
   input  rec_end_type         rec,
   output rsp_payload_type     result
);

   localparam int WideW = (SEGMENT_BITS > LimitW) ? SEGMENT_BITS : LimitW;
   localparam int SumW  = ((SEGMENT_BITS > LenW) ? SEGMENT_BITS : LenW) + 2;

   logic [SEGMENT_BITS-1:0] fill_ff, fill_in;
   logic [SEGMENT_BITS-1:0] limit_seg, offset_seg, fill_sat;
   logic [WideW-1:0]        limit_wide, offset_wide;
   logic [SumW-1:0]         rec_size, fill_x, limit_x, base, total, seg_max;
   logic                    roll;

   always_comb begin
      limit_wide = WideW'(limit);
      limit_seg  = limit_wide[SEGMENT_BITS-1:0];
      fill_x     = SumW'(fill_ff);
      limit_x    = SumW'(limit_seg);
      seg_max    = SumW'({SEGMENT_BITS{1'b1}});
      rec_size   = SumW'(rec.length) + SumW'(HeaderBytes);

      // an empty segment never rolls; one already past the limit always does
      roll = (fill_ff != '0) && ((fill_x > limit_x) || (rec_size > limit_x - fill_x));

      base     = roll ? '0 : fill_x;
      total    = base + rec_size;
      fill_sat = (total > seg_max) ? '1 : total[SEGMENT_BITS-1:0];

      offset_seg  = roll ? '0 : fill_ff;
      offset_wide = WideW'(offset_seg);

      if (rec.overflow) begin
         result = '0;
         result.length_error = 1'b1;
      end else begin
         result.payload_length    = rec.length;
         result.payload_crc       = rec.crc;
         result.start_new_segment = roll;
         result.record_offset     = offset_wide[OffW-1:0];
         result.length_error      = 1'b0;
      end

      fill_in = (take && !rec.overflow) ? fill_sat : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

### sv/log_record_framer_crc32.sv
// channel   dir  handshake        payload
// req_ch    in   valid/ready      data_byte, byte_present, last_byte
// rsp_ch    out  valid/ready      payload_length, payload_crc, start_new_segment,
//                                 record_offset, length_error
// apb       in   psel/penable     segment_limit_bytes at byte address 0
//
// one request per cycle while req_ch.ready is high; crc and count update in the cycle a request is taken
// a last request reaches rsp_ch through the record-end register, then
// segment accounting into the output register
// synchronous reset restores crc preset, zero count, empty segment, default limit
// a stalled rsp_ch backs up through the record-end stage to req_ch.ready
module log_record_framer_crc32
   import lrf_pkg::*;
#(
   parameter int LENGTH_BITS  = 32,
   parameter int SEGMENT_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   lrf_req_if.sink              req_ch,
   lrf_rsp_if.source            rsp_ch,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CsrAddrW-1:0]  paddr,
   input  logic [CsrDataW-1:0]  pwdata,
   output logic [CsrDataW-1:0]  prdata,
   output logic                 pready
);

   logic [LimitW-1:0]      limit_ff, limit_in;
   logic [CrcW-1:0]        crc_ff, crc_in, crc_upd;
   logic [LENGTH_BITS-1:0] count_ff, count_in, count_upd;
   logic                   ovf_ff, ovf_in, ovf_upd;
   logic                   b_valid_ff, b_valid_in;
   rec_end_type            b_rec_ff, b_rec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in, seg_result;
   logic                   req_take, rec_end, b_take, csr_write, cnt_max;

   // configuration
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[CsrAddrW-1] == RegSegmentLimit);
   assign limit_in  = csr_write ? pwdata[LimitW-1:0] : limit_ff;

   always_comb begin
      prdata = '0;
      if (paddr[CsrAddrW-1] == RegSegmentLimit) begin
         prdata = CsrDataW'(limit_ff);
      end
   end

   // handshakes
   assign b_take       = b_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !b_valid_ff || b_take;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rec_end      = req_take && req_ch.last_byte;

   // per-byte record state
   always_comb begin
      cnt_max   = &count_ff;
      crc_upd   = req_ch.byte_present ? crc_byte(crc_ff, req_ch.data_byte) : crc_ff;
      ovf_upd   = ovf_ff || (req_ch.byte_present && cnt_max);
      count_upd = (req_ch.byte_present && !cnt_max) ? count_ff + LENGTH_BITS'(1) : count_ff;

      crc_in   = crc_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (req_take) begin
         if (req_ch.last_byte) begin
            crc_in   = CrcPreset;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            crc_in   = crc_upd;
            count_in = count_upd;
            ovf_in   = ovf_upd;
         end
      end

      b_rec_in.length   = LenW'(count_upd);
      b_rec_in.crc      = ~crc_upd;
      b_rec_in.overflow = ovf_upd;

      b_valid_in = rec_end ? 1'b1 : (b_take ? 1'b0 : b_valid_ff);
      rsp_valid_in = b_take ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      rsp_in = seg_result;
   end

   lrf_segment #(
      .SEGMENT_BITS(SEGMENT_BITS)
   ) u_segment (
      .clock (clock),
      .reset (reset),
      .limit (limit_ff),
      .take  (b_take),
      .rec   (b_rec_ff),
      .result(seg_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitReset;
         crc_ff       <= CrcPreset;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_end) begin
         b_rec_ff <= b_rec_in;
      end
      if (b_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.payload_length    = rsp_ff.payload_length;
   assign rsp_ch.payload_crc       = rsp_ff.payload_crc;
   assign rsp_ch.start_new_segment = rsp_ff.start_new_segment;
   assign rsp_ch.record_offset     = rsp_ff.record_offset;
   assign rsp_ch.length_error      = rsp_ff.length_error;

`ifndef ASSERT_OFF
   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.length_error |->
         rsp_ff.payload_length == '0 && rsp_ff.payload_crc == '0 &&
         !rsp_ff.start_new_segment && rsp_ff.record_offset == '0)
      else $error("rejected record carries nonzero fields");

   a_roll_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.start_new_segment |-> rsp_ff.record_offset == '0)
      else $error("new segment with nonzero offset");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> crc_ff == CrcPreset && count_ff == '0 && !ovf_ff)
      else $error("record state not cleared by reset");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      rec_end |=> crc_ff == CrcPreset && count_ff == '0 && !ovf_ff && b_valid_ff)
      else $error("record state not cleared at record end");
`endif

endmodule

### tb/log_record_framer_crc32_tb.sv
module log_record_framer_crc32_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrf_pkg::*;

   localparam int StallLimit = 1000;
   localparam logic [CsrAddrW-1:0] LimitAddr = CsrAddrW'(8 * RegSegmentLimit);
   localparam logic [CsrAddrW-1:0] SpareAddr = LimitAddr + CsrAddrW'(8);
   localparam logic [OffW-1:0] FillMax = '1;

   class framer_scoreboard;
      logic [LimitW-1:0] limit;
      logic [CrcW-1:0]   crc;
      logic [LenW-1:0]   length;
      bit                overflowed;
      logic [OffW-1:0]   fill;
      rsp_payload_type   expected_headers[$];
      int                failures;

      function new();
         limit = LimitReset;
         fill = '0;
         crc = CrcPreset;
         length = '0;
         overflowed = 1'b0;
         failures = 0;
      endfunction

      function logic [CrcW-1:0] crc32_update(logic [CrcW-1:0] c, logic [DataW-1:0] d);
         logic [CrcW-1:0] r;
         r = c;
         for (int k = 0; k < DataW; k++) begin
            if (r[0] ^ d[k]) r = (r >> 1) ^ CrcPoly;
            else r = r >> 1;
         end
         return r;
      endfunction

      function void note_request(logic [DataW-1:0] data, logic present, logic last);
         rsp_payload_type hdr;
         logic [63:0]     rec_size;
         logic [63:0]     new_fill;
         bit              roll;
         if (present) begin
            crc = crc32_update(crc, data);
            if (length == '1) overflowed = 1'b1;
            else length++;
         end
         if (!last) return;
         hdr = '0;
         if (overflowed) begin
            hdr.length_error = 1'b1;
         end else begin
            rec_size = 64'(HeaderBytes) + 64'(length);
            // a non-empty segment already past a lowered limit always rolls
            if (fill == '0) roll = 1'b0;
            else if (fill > limit) roll = 1'b1;
            else roll = rec_size > 64'(limit - fill);
            if (roll) new_fill = rec_size;
            else if (rec_size > 64'(FillMax - fill)) new_fill = 64'(FillMax);
            else new_fill = 64'(fill) + rec_size;
            if (new_fill > 64'(FillMax)) new_fill = 64'(FillMax);
            hdr.payload_length = length;
            hdr.payload_crc = ~crc;
            hdr.start_new_segment = roll;
            hdr.record_offset = roll ? '0 : fill;
            fill = new_fill[OffW-1:0];
         end
         crc = CrcPreset;
         length = '0;
         overflowed = 1'b0;
         expected_headers.push_back(hdr);
      endfunction

      function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (act_v !== exp_v) begin
            failures++;
            if (failures <= 10)
               $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
         end
      endfunction

      function void check_header(rsp_payload_type got);
         rsp_payload_type exp_hdr;
         if (expected_headers.size() == 0) begin
            failures++;
            if (failures <= 10) $display("%0t: unexpected response %h", $realtime, got);
            return;
         end
         exp_hdr = expected_headers.pop_front();
         compare_field("payload_length", 64'(exp_hdr.payload_length), 64'(got.payload_length));
         compare_field("payload_crc", 64'(exp_hdr.payload_crc), 64'(got.payload_crc));
         compare_field("start_new_segment", 64'(exp_hdr.start_new_segment),
                       64'(got.start_new_segment));
         compare_field("record_offset", 64'(exp_hdr.record_offset), 64'(got.record_offset));
         compare_field("length_error", 64'(exp_hdr.length_error), 64'(got.length_error));
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CsrAddrW-1:0] paddr;
   logic [CsrDataW-1:0] pwdata;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   lrf_req_if req_ch();
   lrf_rsp_if rsp_ch();

   framer_scoreboard scoreboard;
   bit               steady;
   int               items_sent;
   int               stall_cycles;

   log_record_framer_crc32 DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= 13);
   end

   // request/response monitor and stall watchdog
   always @(posedge clock) begin
      rsp_payload_type got;
      bit              moved;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            scoreboard.note_request(req_ch.data_byte, req_ch.byte_present, req_ch.last_byte);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.payload_length = rsp_ch.payload_length;
            got.payload_crc = rsp_ch.payload_crc;
            got.start_new_segment = rsp_ch.start_new_segment;
            got.record_offset = rsp_ch.record_offset;
            got.length_error = rsp_ch.length_error;
            scoreboard.check_header(got);
            moved = 1'b1;
         end
         if (moved) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_request(logic [DataW-1:0] data, logic present, logic last);
      while (!steady && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.byte_present <= present;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (present || last) items_sent++;
   endtask

   task automatic send_record(int unsigned n);
      bit close_on_byte;
      close_on_byte = (n != 0) && ($urandom_range(9) < 7);
      for (int unsigned i = 0; i < n; i++) begin
         // filler request with no byte, ignored by the block
         if ($urandom_range(19) == 0) send_request(DataW'($urandom), 1'b0, 1'b0);
         send_request(DataW'($urandom), 1'b1, close_on_byte && (i == n - 1));
      end
      if (!close_on_byte) send_request(DataW'($urandom), 1'b0, 1'b1);
   endtask

   task automatic send_records(int target);
      int          stop_at;
      int unsigned pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 5) send_record(0);
         else if (pick < 90) send_record($urandom_range(1, 24));
         else send_record($urandom_range(25, 300));
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_headers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrAddrW-1:0] addr, logic [LimitW-1:0] value);
      logic [CsrDataW-1:0] word;
      word = {16'($urandom), value};
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == LimitAddr) scoreboard.limit = word[LimitW-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      scoreboard = new();
      clock = 1'b0;
      reset = 1'b1;
      steady = 1'b0;
      items_sent = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.byte_present = 1'b0;
      req_ch.last_byte = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty record, single-byte extremes, check string, fillers and a bare close
      send_request(8'hA5, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      for (int i = 0; i < 9; i++) send_request(DataW'(8'h31 + i), 1'b1, i == 8);
      send_request(8'h3C, 1'b0, 1'b0);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'hC3, 1'b0, 1'b0);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);
      drain();

      write_csr(LimitAddr, 48'd100);
      send_records(400);
      drain();
      write_csr(LimitAddr, '0);
      send_records(200);
      drain();
      steady = 1'b1;
      write_csr(LimitAddr, '1);
      send_records(400);
      drain();
      steady = 1'b0;
      // limit drops below the current fill
      write_csr(LimitAddr, 48'd20);
      send_records(250);
      drain();
      write_csr(SpareAddr, LimitW'({$urandom, $urandom}));
      send_records(150);
      drain();
      write_csr(LimitAddr, LimitW'($urandom_range(16, 600)));
      send_records(300);
      drain();
      write_csr(LimitAddr, LimitReset);
      send_records(300);
      drain();

      if (scoreboard.failures == 0 && scoreboard.expected_headers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
